### hw/rtl/snm3_pkg.sv
// Shared types and constants for the 3D hashed simplex noise pipeline.
package snm3_pkg;

   typedef logic [31:0] word_type;
   typedef logic [2:0]  gsel_type;

   localparam int NUM_AXES    = 3;
   localparam int NUM_CORNERS = 4;
   localparam int HASH_DEPTH  = 7;

   localparam word_type LCG_MUL = 32'd1664525;
   localparam word_type LCG_ADD = 32'd1013904223;

   // Floor division by three: offset to non-negative, then (u * RECIP3) >> 33.
   localparam word_type RECIP3    = 32'hAAAA_AAAB;
   localparam word_type DIV3_BIAS = 32'h1800_0000;
   localparam word_type DIV3_BASE = 32'h0800_0000;

   // Floor division by nine of a 20-bit value: (x * RECIP9) >> 23.
   localparam logic [19:0] RECIP9 = 20'd932068;

   // Final scaling: floor division by 1125 of a 27-bit value: (u * RECIP1125) >> 37.
   localparam logic [26:0] RECIP1125 = 27'd122167959;
   localparam int          SAT_BIAS  = 36864000;
   localparam int          HALF_DIV  = 1125;

endpackage

### hw/rtl/snm3_hash.sv
// Pipelined LCG-plus-mix hash of one corner, seven register stages.
module snm3_hash (
   input  logic                clock,
   input  logic                en,
   input  snm3_pkg::word_type  hw_in [3],
   output snm3_pkg::gsel_type  sel   [3]
);
   import snm3_pkg::*;

   word_type hs_ff [HASH_DEPTH][NUM_AXES];

   // Stage zero is the LCG; each later stage updates one word by the product of the
   // other two, in the order a, b, c, a, b, c.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            hs_ff[0][i] <= hw_in[i] * LCG_MUL + LCG_ADD;
         end
         for (int s = 1; s < HASH_DEPTH; s++) begin
            for (int i = 0; i < NUM_AXES; i++) begin
               if (i == ((s - 1) % NUM_AXES)) begin
                  hs_ff[s][i] <= hs_ff[s-1][i]
                     + hs_ff[s-1][(i + 1) % NUM_AXES] * hs_ff[s-1][(i + 2) % NUM_AXES];
               end else begin
                  hs_ff[s][i] <= hs_ff[s-1][i];
               end
            end
         end
      end
   end

   // Bits 3, 2 and 1 of the word shifted down by sixteen.
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         sel[i] = hs_ff[HASH_DEPTH-1][i][19:17];
      end
   end

endmodule

### hw/rtl/simplex_noise_3d_hashed.sv
// Top level of the 3D hashed simplex noise pipeline.
//
//   Channel   Direction  Handshake                Payload
//   req_      in         req_tvalid/req_tready    req_tdata: coord_x, coord_y, coord_z
//   rsp_      out        rsp_tvalid/rsp_tready    rsp_tdata: noise_x, noise_y, noise_z
//   csr_      in         csr_valid/csr_ready      csr_data: output_mode
//
// The pipeline is 17 register stages deep and accepts one beat every cycle unless
// stalled; each result is presented from the output register and can be accepted
// at the next edge. The depth is set by the seven
// serial 32-bit multiply stages of the corner hash plus the skew, weight and
// output scaling stages around it. All stages advance together on one enable,
// which is low only while a result sits in the output register and the consumer
// holds rsp_tready low, so a stall freezes every stage and loses nothing.
// Reset clears the valid bits and output_mode; data registers are not reset.
module simplex_noise_3d_hashed #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // coord_x [31:0], coord_y [63:32], coord_z [95:64]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // noise_x [15:0], noise_y [31:16], noise_z [47:32]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);
   import snm3_pkg::*;

   localparam int PIPE_DEPTH = 17;
   localparam int FW  = FRAC_BITS + 6;       // offsets in sixths, |f| < 32 units
   localparam int DW  = 2 * FW + 2;          // squared distance
   localparam int XSH = 2 * FRAC_BITS - 15;  // divisor is 9 << XSH
   localparam int GW  = FW + 2;              // gradient dot product
   localparam int TW  = FW + 28;             // one weighted term
   localparam int AW  = FW + 30;             // accumulated sum
   localparam logic [DW-1:0]        QFULL = DW'(18) << (2 * FRAC_BITS);
   localparam logic signed [AW-1:0] VHALF = AW'(HALF_DIV) <<< FRAC_BITS;
   localparam logic signed [AW-1:0] VMAX  = AW'(SAT_BIAS - 1);
   localparam logic signed [AW-1:0] VMIN  = AW'(-SAT_BIAS);

   logic en;
   logic [PIPE_DEPTH:1] vld_ff;
   logic mode_ff;

   assign en         = !vld_ff[PIPE_DEPTH] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[PIPE_DEPTH];
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         mode_ff <= 1'b0;
      end else begin
         if (en) begin
            vld_ff <= {vld_ff[PIPE_DEPTH-1:1], req_tvalid};
         end
         if (csr_valid) begin
            mode_ff <= csr_data;
         end
      end
   end

   // Stage 1: capture the point.
   logic signed [31:0] p1_ff [NUM_AXES];
   // Stage 2: biased floor((3p + sum) / 2^F), ready for division by three.
   logic signed [31:0] p2_ff [NUM_AXES];
   word_type           u2_ff [NUM_AXES];
   // Stage 3: skewed cell coordinate.
   logic signed [31:0] p3_ff  [NUM_AXES];
   word_type           tb3_ff [NUM_AXES];
   // Stage 4: cell corner in sixths and offset from it.
   word_type           b6_ff [NUM_AXES];
   logic signed [FW-1:0] tf_ff [NUM_AXES];
   // Stage 5: per-corner offsets and hash inputs.
   logic signed [FW-1:0] f5_ff  [NUM_CORNERS][NUM_AXES];
   word_type             hw5_ff [NUM_CORNERS][NUM_AXES];

   logic signed [33:0] sum2;
   logic signed [35:0] n2  [NUM_AXES];
   logic signed [35:0] m2  [NUM_AXES];
   logic [63:0]        q3  [NUM_AXES];
   word_type           tsum4;
   logic [FW-1:0]      sixp4 [NUM_AXES];
   word_type           b6n4  [NUM_AXES];
   logic               gt5 [NUM_AXES];
   logic               lt5 [NUM_AXES];
   logic signed [3:0]  off5 [NUM_CORNERS][NUM_AXES];
   logic signed [FW-1:0] offw5 [NUM_CORNERS][NUM_AXES];

   always_comb begin
      sum2 = 34'(p1_ff[0]) + 34'(p1_ff[1]) + 34'(p1_ff[2]);
      for (int i = 0; i < NUM_AXES; i++) begin
         n2[i] = (36'(p1_ff[i]) <<< 1) + 36'(p1_ff[i]) + 36'(sum2);
         m2[i] = n2[i] >>> FRAC_BITS;
         q3[i] = {32'b0, u2_ff[i]} * {32'b0, RECIP3};
      end
      tsum4 = tb3_ff[0] + tb3_ff[1] + tb3_ff[2];
      for (int i = 0; i < NUM_AXES; i++) begin
         b6n4[i]  = (tb3_ff[i] << 2) + (tb3_ff[i] << 1) - tsum4;
         sixp4[i] = (FW'(p3_ff[i]) << 2) + (FW'(p3_ff[i]) << 1);
      end
      // Tetrahedron choice: a tie counts the earlier-compared component as larger.
      gt5[0] = tf_ff[0] >= tf_ff[1];
      gt5[1] = tf_ff[1] >= tf_ff[2];
      gt5[2] = tf_ff[2] >= tf_ff[0];
      lt5[0] = !gt5[2];
      lt5[1] = !gt5[0];
      lt5[2] = !gt5[1];
      for (int i = 0; i < NUM_AXES; i++) begin
         off5[0][i] = 4'sd0;
         off5[1][i] = (gt5[i] && lt5[i]) ? 4'sd5 : -4'sd1;
         off5[2][i] = (gt5[i] || lt5[i]) ? 4'sd4 : -4'sd2;
         off5[3][i] = 4'sd3;
         for (int k = 0; k < NUM_CORNERS; k++) begin
            offw5[k][i] = FW'(off5[k][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            p1_ff[i]  <= req_tdata[32*i +: 32];
            p2_ff[i]  <= p1_ff[i];
            u2_ff[i]  <= m2[i][31:0] + DIV3_BIAS;
            p3_ff[i]  <= p2_ff[i];
            tb3_ff[i] <= 32'(q3[i][63:33]) - DIV3_BASE;
            b6_ff[i]  <= b6n4[i];
            tf_ff[i]  <= $signed(sixp4[i] - (FW'(b6n4[i][5:0]) << FRAC_BITS));
            for (int k = 0; k < NUM_CORNERS; k++) begin
               f5_ff[k][i]  <= tf_ff[i] - (offw5[k][i] <<< FRAC_BITS);
               hw5_ff[k][i] <= b6_ff[i] + 32'(off5[k][i]);
            end
         end
      end
   end

   // Stages 6 to 12: corner hashes.
   gsel_type sel12 [NUM_CORNERS][NUM_AXES];

   for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_hash
      snm3_hash u_hash (
         .clock (clock),
         .en    (en),
         .hw_in (hw5_ff[k]),
         .sel   (sel12[k])
      );
   end

   // Stages 6 to 10 in parallel: falloff weight t^3 per corner.
   logic [2*FW-1:0] sq6_ff   [NUM_CORNERS][NUM_AXES];
   logic [19:0]     x7_ff    [NUM_CORNERS];
   logic [16:0]     t16_8_ff [NUM_CORNERS];
   logic [16:0]     t16_9_ff [NUM_CORNERS];
   logic [33:0]     tsq9_ff  [NUM_CORNERS];
   logic [24:0]     t3_ff    [3][NUM_CORNERS];
   logic signed [FW-1:0] fd_ff [HASH_DEPTH][NUM_CORNERS][NUM_AXES];

   logic signed [2*FW-1:0] sq6  [NUM_CORNERS][NUM_AXES];
   logic [DW-1:0]          d7   [NUM_CORNERS];
   logic [DW-1:0]          dif7 [NUM_CORNERS];
   logic [39:0]            r8   [NUM_CORNERS];
   logic [50:0]            c10  [NUM_CORNERS];

   always_comb begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            sq6[k][i] = f5_ff[k][i] * f5_ff[k][i];
         end
         d7[k]   = DW'(sq6_ff[k][0]) + DW'(sq6_ff[k][1]) + DW'(sq6_ff[k][2]);
         dif7[k] = (d7[k] < QFULL) ? (QFULL - d7[k]) >> XSH : '0;
         r8[k]   = {20'b0, x7_ff[k]} * {20'b0, RECIP9};
         c10[k]  = {17'b0, tsq9_ff[k]} * {34'b0, t16_9_ff[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NUM_CORNERS; k++) begin
            for (int i = 0; i < NUM_AXES; i++) begin
               sq6_ff[k][i] <= sq6[k][i];
            end
            x7_ff[k]    <= dif7[k][19:0];
            t16_8_ff[k] <= r8[k][39:23];
            t16_9_ff[k] <= t16_8_ff[k];
            tsq9_ff[k]  <= {17'b0, t16_8_ff[k]} * {17'b0, t16_8_ff[k]};
            t3_ff[0][k] <= c10[k][48:24];
            t3_ff[1][k] <= t3_ff[0][k];
            t3_ff[2][k] <= t3_ff[1][k];
         end
         fd_ff[0] <= f5_ff;
         for (int s = 1; s < HASH_DEPTH; s++) begin
            fd_ff[s] <= fd_ff[s-1];
         end
      end
   end

   // Stages 13 to 17: gradient dot products, weighting, sum and output scaling.
   logic signed [GW-1:0] g13_ff   [NUM_CORNERS][NUM_AXES];
   logic [24:0]          t3_13_ff [NUM_CORNERS];
   logic signed [TW-1:0] tm14_ff  [NUM_CORNERS][NUM_AXES];
   logic signed [AW-1:0] acc15_ff [NUM_AXES];
   logic [26:0]          u16_ff   [NUM_AXES];
   logic [47:0]          out_ff;

   logic signed [GW-1:0] fx13 [NUM_CORNERS][NUM_AXES];
   logic signed [GW-1:0] gd13 [NUM_CORNERS][NUM_AXES];
   logic signed [AW-1:0] sh16 [NUM_AXES];
   logic signed [AW-1:0] cl16 [NUM_AXES];
   logic signed [AW-1:0] ub16 [NUM_AXES];
   logic [53:0]          q17  [NUM_AXES];
   logic [15:0]          r17  [NUM_AXES];

   always_comb begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
         for (int j = 0; j < NUM_AXES; j++) begin
            fx13[k][j] = GW'(fd_ff[HASH_DEPTH-1][k][j]);
         end
         // Hash word i picks the sign of each offset component for output i.
         for (int i = 0; i < NUM_AXES; i++) begin
            gd13[k][i] = (sel12[k][i][2] ? fx13[k][0] : -fx13[k][0])
                       + (sel12[k][i][1] ? fx13[k][1] : -fx13[k][1])
                       + (sel12[k][i][0] ? fx13[k][2] : -fx13[k][2]);
         end
      end
      for (int i = 0; i < NUM_AXES; i++) begin
         // Round to nearest after dividing by 2250 * 2^F; clamping first keeps the
         // remaining division by 1125 narrow.
         sh16[i] = (acc15_ff[i] + VHALF) >>> (FRAC_BITS + 1);
         if (sh16[i] > VMAX) begin
            cl16[i] = VMAX;
         end else if (sh16[i] < VMIN) begin
            cl16[i] = VMIN;
         end else begin
            cl16[i] = sh16[i];
         end
         ub16[i] = cl16[i] - VMIN;
         q17[i]  = {27'b0, u16_ff[i]} * {27'b0, RECIP1125};
         r17[i]  = q17[i][52:37] ^ 16'h8000;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NUM_CORNERS; k++) begin
            t3_13_ff[k] <= t3_ff[2][k];
            for (int i = 0; i < NUM_AXES; i++) begin
               g13_ff[k][i]  <= gd13[k][i];
               tm14_ff[k][i] <= $signed({1'b0, t3_13_ff[k]}) * g13_ff[k][i];
            end
         end
         for (int i = 0; i < NUM_AXES; i++) begin
            acc15_ff[i] <= AW'(tm14_ff[0][i]) + AW'(tm14_ff[1][i])
                         + AW'(tm14_ff[2][i]) + AW'(tm14_ff[3][i]);
            u16_ff[i]   <= ub16[i][26:0];
         end
         out_ff[15:0]  <= r17[0];
         out_ff[31:16] <= mode_ff ? r17[1] : 16'h0000;
         out_ff[47:32] <= mode_ff ? r17[2] : 16'h0000;
      end
   end

   assign rsp_tdata = out_ff;

   a_mode_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !mode_ff) |-> (rsp_tdata[47:16] == 32'h0))
      else $error("noise_y or noise_z nonzero in single-output mode");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline valid bits moved during a stall");

   a_weight_range : assert property (@(posedge clock) disable iff (reset)
      vld_ff[8] |-> (t16_8_ff[0] <= 17'd65536 && t16_8_ff[3] <= 17'd65536))
      else $error("falloff weight above one");

   a_scale_range : assert property (@(posedge clock) disable iff (reset)
      vld_ff[16] |-> (u16_ff[0] < 27'd73728000))
      else $error("clamped sum outside the output range");

endmodule

### sim/tb.sv
// Self-checking testbench for the 3D hashed simplex noise pipeline.
`timescale 1ns / 1ps

module tb;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;    // coord_x [31:0], coord_y [63:32], coord_z [95:64]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;    // noise_x [15:0], noise_y [31:16], noise_z [47:32]
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_data;

   localparam int FRAC = 16;
   localparam int PIPE_DEPTH = 17;

   typedef struct packed {
      logic signed [15:0] nz;
      logic signed [15:0] ny;
      logic signed [15:0] nx;
   } noise_type;

   // One row of the directed table. When has_gold is set the noise value is
   // known by inspection and is checked directly against the predictor too.
   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      bit          has_gold;
      noise_type   gold;
   } point_row_type;

   noise_type pending_noise[$];
   logic    mode_shadow;
   int      fail_count;
   int      send_idle_pct;
   int      recv_idle_pct;

   simplex_noise_3d_hashed #(.FRAC_BITS(FRAC)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   initial begin
      #50_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic longint floor_quot(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && ((a < 0) != (b < 0))) q = q - 1;
      return q;
   endfunction

   function automatic logic [15:0] clamp_q214(longint acc);
      longint divisor;
      longint r;
      divisor = longint'(2250) << FRAC;
      r = floor_quot(acc + divisor / 2, divisor);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   // Hash of one corner; returns three 16-bit words in the low bits.
   function automatic void corner_hash(input logic [31:0] cx, input logic [31:0] cy,
                                       input logic [31:0] cz, output logic [31:0] hx,
                                       output logic [31:0] hy, output logic [31:0] hz);
      logic [31:0] a, b, c;
      a = cx * 32'd1664525 + 32'd1013904223;
      b = cy * 32'd1664525 + 32'd1013904223;
      c = cz * 32'd1664525 + 32'd1013904223;
      a += b * c; b += c * a; c += a * b;
      a += b * c; b += c * a; c += a * b;
      hx = a >> 16; hy = b >> 16; hz = c >> 16;
   endfunction

   function automatic longint gradient_dot(logic [31:0] w, longint fx, longint fy,
                                           longint fz);
      longint g;
      g  = w[3] ? fx : -fx;
      g += w[2] ? fy : -fy;
      g += w[1] ? fz : -fz;
      return g;
   endfunction

   // Noise value of one point under the current output_mode.
   function automatic noise_type simplex_noise(logic [31:0] x, logic [31:0] y,
                                               logic [31:0] z, logic mode);
      longint one, qfull, tdiv, total, tsum, d, t16, t3;
      longint p[3], lattice[3], base6[3], frac6[3], f[3], acc[3];
      int ge[3], lt[3], offs[4][3], mn, mx;
      logic [31:0] hw[3];
      noise_type n;
      one   = longint'(1) << FRAC;
      qfull = longint'(18) << (2 * FRAC);
      tdiv  = longint'(18) << (2 * FRAC - 16);
      p[0] = longint'($signed(x));
      p[1] = longint'($signed(y));
      p[2] = longint'($signed(z));
      total = p[0] + p[1] + p[2];
      for (int i = 0; i < 3; i++) lattice[i] = floor_quot(3 * p[i] + total, 3 * one);
      tsum = lattice[0] + lattice[1] + lattice[2];
      for (int i = 0; i < 3; i++) begin
         base6[i] = 6 * lattice[i] - tsum;
         frac6[i] = 6 * p[i] - base6[i] * one;
      end
      // Ties count the first component as the larger one.
      ge[0] = frac6[0] >= frac6[1];
      ge[1] = frac6[1] >= frac6[2];
      ge[2] = frac6[2] >= frac6[0];
      lt[0] = 1 - ge[2];
      lt[1] = 1 - ge[0];
      lt[2] = 1 - ge[1];
      for (int i = 0; i < 3; i++) begin
         mn = ge[i] < lt[i] ? ge[i] : lt[i];
         mx = ge[i] > lt[i] ? ge[i] : lt[i];
         offs[0][i] = 0;
         offs[1][i] = 6 * mn - 1;
         offs[2][i] = 6 * mx - 2;
         offs[3][i] = 3;
         acc[i] = 0;
      end
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 3; i++) f[i] = frac6[i] - longint'(offs[k][i]) * one;
         corner_hash(32'(base6[0] + offs[k][0]), 32'(base6[1] + offs[k][1]),
                     32'(base6[2] + offs[k][2]), hw[0], hw[1], hw[2]);
         d = f[0] * f[0] + f[1] * f[1] + f[2] * f[2];
         t16 = (d < qfull) ? (qfull - d) / tdiv : 0;
         t3 = longint'((64'(t16) * 64'(t16) * 64'(t16)) >> 24);
         for (int i = 0; i < 3; i++) acc[i] += t3 * gradient_dot(hw[i], f[0], f[1], f[2]);
      end
      n.nx = clamp_q214(acc[0]);
      n.ny = mode ? clamp_q214(acc[1]) : 16'sd0;
      n.nz = mode ? clamp_q214(acc[2]) : 16'sd0;
      return n;
   endfunction

   // Offer one point and wait until the pipeline takes it. The valid stays high
   // into the next beat unless the sender idles first.
   task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x};
      pending_noise.push_back(simplex_noise(x, y, z, mode_shadow));
      do @(posedge clock); while (!req_tready);
   endtask

   // Drain, let the pipe settle, then write output_mode.
   task automatic write_mode(logic mode);
      req_tvalid <= 1'b0;
      while (pending_noise.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 3) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mode_shadow = mode;
   endtask

   // Random coordinate: mostly modest values near the origin, some anywhere.
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
         default: return 32'($signed($urandom_range(32'h0006_0000)) - 32'sh0003_0000);
      endcase
   endfunction

   // Receiver: random back-pressure, checks each beat against the oldest prediction.
   always @(posedge clock) begin
      noise_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_noise.size() == 0) begin
               $display("%0t unexpected beat: expected none, actual %h", $time, got);
               fail_count++;
            end else begin
               want = pending_noise.pop_front();
               if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz) begin
                  $display({"%0t noise mismatch: expected x=%0d y=%0d z=%0d,",
                            " actual x=%0d y=%0d z=%0d"},
                           $time, want.nx, want.ny, want.nz, got.nx, got.ny, got.nz);
                  fail_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      point_row_type rows[$];
      point_row_type r;
      noise_type pred;
      int waited;
      fail_count = 0;
      mode_shadow = 1'b0;
      send_idle_pct = 31;
      recv_idle_pct = 83;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_data = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // At the origin the first corner sits on the point itself and the second
      // corner lies inside the falloff radius.
      r = '{32'h0, 32'h0, 32'h0, 1'b0, '0}; rows.push_back(r);
      // Integer lattice points.
      r = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, '0}; rows.push_back(r);
      r = '{32'hFFFF_0000, 32'h0, 32'h0001_0000, 1'b0, '0}; rows.push_back(r);
      // Extremes of each field, including corner wrap in the hash.
      r = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0}; rows.push_back(r);
      r = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0}; rows.push_back(r);
      r = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0, '0}; rows.push_back(r);
      r = '{32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 1'b0, '0}; rows.push_back(r);
      r = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0}; rows.push_back(r);
      r = '{32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b0, '0}; rows.push_back(r);
      // Ties in the tetrahedron choice.
      r = '{32'h0000_4000, 32'h0000_4000, 32'h0000_2000, 1'b0, '0}; rows.push_back(r);
      r = '{32'h0000_2000, 32'h0000_4000, 32'h0000_4000, 1'b0, '0}; rows.push_back(r);
      r = '{32'h0000_4000, 32'h0000_2000, 32'h0000_4000, 1'b0, '0}; rows.push_back(r);
      // One point in each of the six tetrahedra, and a point in another cell.
      r = '{32'h0000_6000, 32'h0000_4000, 32'h0000_2000, 1'b0, '0}; rows.push_back(r);
      r = '{32'h0000_6000, 32'h0000_2000, 32'h0000_4000, 1'b0, '0}; rows.push_back(r);
      r = '{32'h0000_4000, 32'h0000_6000, 32'h0000_2000, 1'b0, '0}; rows.push_back(r);
      r = '{32'h0000_2000, 32'h0000_6000, 32'h0000_4000, 1'b0, '0}; rows.push_back(r);
      r = '{32'h0000_4000, 32'h0000_2000, 32'h0000_6000, 1'b0, '0}; rows.push_back(r);
      r = '{32'h0000_2000, 32'h0000_4000, 32'h0000_6000, 1'b0, '0}; rows.push_back(r);
      r = '{32'hFFFF_9000, 32'h0003_7000, 32'hFFFE_C800, 1'b0, '0}; rows.push_back(r);

      // Run the table in 1D mode (reset value), then in 3D mode.
      for (int pass = 0; pass < 2; pass++) begin
         if (pass == 1) write_mode(1'b1);
         foreach (rows[i]) begin
            if (rows[i].has_gold) begin
               pred = simplex_noise(rows[i].x, rows[i].y, rows[i].z, mode_shadow);
               if (pred !== rows[i].gold) begin
                  $display("%0t predictor disagrees at row %0d: expected %h, actual %h",
                           $time, i, rows[i].gold, pred);
                  fail_count++;
               end
            end
            send_point(rows[i].x, rows[i].y, rows[i].z);
         end
      end

      // Random phases: idling swaps, then stops; output_mode flips between and in them.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 31; recv_idle_pct = 83; write_mode(1'b0); end
            1: begin send_idle_pct = 83; recv_idle_pct = 31; write_mode(1'b1); end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; write_mode(1'b0); end
         endcase
         for (int n = 0; n < 250; n++) begin
            if (phase == 2 && n == 125) write_mode(1'b1);
            send_point(rand_coord(), rand_coord(), rand_coord());
         end
      end
      req_tvalid <= 1'b0;

      waited = 0;
      while (pending_noise.size() != 0 && waited < 200_000) begin
         @(posedge clock);
         waited++;
      end
      repeat (PIPE_DEPTH + 5) @(posedge clock);
      if (fail_count == 0 && pending_noise.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         if (pending_noise.size() != 0)
            $display("%0t %0d results never arrived", $time, pending_noise.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/snm3_pkg.sv
hw/rtl/snm3_hash.sv
hw/rtl/simplex_noise_3d_hashed.sv
sim/tb.sv
